// File: rtl/core/brb_pkg.sv
`timescale 1ns / 1ps

package brb_pkg;

  // default ring depth in bytes, a power of two
  localparam int unsigned DEPTH_DEFAULT = 1024;

  localparam int unsigned FIELD_LEN_W = 11;
  localparam int unsigned MARKER_W    = 32;
  localparam int unsigned MLEN_W      = 3;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_FIND = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_EMPTY     = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    REG_START_MARKER     = 2'd0,
    REG_START_MARKER_LEN = 2'd1,
    REG_END_MARKER       = 2'd2,
    REG_END_MARKER_LEN   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic [7:0]               read_byte;
    logic [FIELD_LEN_W-1:0]   frame_length;
    logic [FIELD_LEN_W-1:0]   fill_level;
  } out_t;

  // control from the sequencer to the marker compare unit
  typedef struct packed {
    logic shift;
    logic clear;
    logic use_end;
  } match_ctl_t;

  // length 0 acts as 1, above 4 acts as 4
  function automatic logic [MLEN_W-1:0] clamp_len(input logic [MLEN_W-1:0] n);
    logic [MLEN_W-1:0] r;
    r = n;
    if (n == '0) begin
      r = MLEN_W'(1);
    end else if (n > MLEN_W'(4)) begin
      r = MLEN_W'(4);
    end
    return r;
  endfunction

endpackage

// File: rtl/core/brb_ram.sv
`timescale 1ns / 1ps

module brb_ram #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/brb_match.sv
`timescale 1ns / 1ps

module brb_match (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  brb_pkg::match_ctl_t                 ctl_i,
  input  logic [7:0]                          byte_i,
  input  logic [brb_pkg::MARKER_W-1:0]        start_marker_i,
  input  logic [brb_pkg::MLEN_W-1:0]          start_len_i,
  input  logic [brb_pkg::MARKER_W-1:0]        end_marker_i,
  input  logic [brb_pkg::MLEN_W-1:0]          end_len_i,
  output logic                                hit_o
);

  logic [3:0][7:0]                   win_q, win_d;
  logic [brb_pkg::MLEN_W-1:0]        cnt_q, cnt_d;
  logic [brb_pkg::MLEN_W-1:0]        len, lenm1;
  logic [brb_pkg::MARKER_W-1:0]      marker;
  logic [1:0]                        mb;
  logic                              all_eq;

  // window after this byte is shifted in, newest byte at position 0
  always_comb begin
    win_d = {win_q[2:0], byte_i};
  end

  always_comb begin
    len    = ctl_i.use_end ? brb_pkg::clamp_len(end_len_i) : brb_pkg::clamp_len(start_len_i);
    marker = ctl_i.use_end ? end_marker_i : start_marker_i;
    lenm1  = len - brb_pkg::MLEN_W'(1);
    all_eq = 1'b1;
    mb     = '0;
    for (int j = 0; j < 4; j++) begin
      mb = 2'(lenm1 - brb_pkg::MLEN_W'(j));
      if ((brb_pkg::MLEN_W'(j) < len) && (win_d[j] != marker[mb*8 +: 8])) begin
        all_eq = 1'b0;
      end
    end
    hit_o = ctl_i.shift && ((cnt_q + brb_pkg::MLEN_W'(1)) >= len) && all_eq;
  end

  // count of bytes in the window, saturating at four
  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.shift && (cnt_q < brb_pkg::MLEN_W'(4))) begin
      cnt_d = cnt_q + brb_pkg::MLEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.shift) begin
      win_q <= win_d;
    end
  end

endmodule

// File: rtl/core/byte_ring_buffer_frame_find.sv
`timescale 1ns / 1ps

// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_ready_o   in_data_i  (brb_pkg::in_t)
// out       source     out_valid_o / out_ready_i out_data_o (brb_pkg::out_t)
// cfg       sink       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// put and unused command: answered straight from idle; get: also waits on the registered ram read
// find: scans up to the fill level, one held byte through the marker compare per cycle
// rst_ni clears pointers, fill count, sequencer and marker registers; ram is not cleared
// in_ready_o is low while a get or find is under way and while an untaken result blocks
// the output register

module byte_ring_buffer_frame_find #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brb_pkg::PADDR_W-1:0]  paddr,
  input  logic [brb_pkg::PDATA_W-1:0]  pwdata,
  output logic [brb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  // request beats
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  brb_pkg::in_t                 in_data_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output brb_pkg::out_t                out_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = AW + 1;
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_GET  = 3'b010,
    ST_FIND = 3'b100
  } state_e;

  state_e state_q, state_d;

  // marker registers
  logic [brb_pkg::MARKER_W-1:0] start_marker_q, end_marker_q;
  logic [brb_pkg::MLEN_W-1:0]   start_len_q, end_len_q;
  logic                         cfg_wr;
  brb_pkg::reg_idx_e            reg_idx;

  // ring pointers and fill count
  logic [AW-1:0] wp_q, wp_d;
  logic [AW-1:0] rp_q, rp_d;
  logic [CW-1:0] fill_q, fill_d;

  // find scan: next offset to read, offset of the byte now on the ram output
  logic [CW-1:0] rd_idx_q, rd_idx_d;
  logic [CW-1:0] idx_q, idx_d;
  logic          dv_q, dv_d;
  logic          end_phase_q, end_phase_d;
  logic [CW-1:0] s_q, s_d;
  logic [CW-1:0] e_off;
  logic [brb_pkg::MLEN_W-1:0] slen, elen;

  // result register
  logic          out_valid_q, out_valid_d;
  brb_pkg::out_t out_q, out_d;

  // ram and compare unit hookup
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;
  brb_pkg::match_ctl_t mctl;
  logic          hit;

  logic in_fire;

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = brb_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    unique case (reg_idx)
      brb_pkg::REG_START_MARKER:     prdata = start_marker_q;
      brb_pkg::REG_START_MARKER_LEN: prdata = brb_pkg::PDATA_W'(start_len_q);
      brb_pkg::REG_END_MARKER:       prdata = end_marker_q;
      brb_pkg::REG_END_MARKER_LEN:   prdata = brb_pkg::PDATA_W'(end_len_q);
      default:                       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_marker_q <= '0;
      start_len_q    <= brb_pkg::MLEN_W'(1);
      end_marker_q   <= '0;
      end_len_q      <= brb_pkg::MLEN_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_idx)
        brb_pkg::REG_START_MARKER:     start_marker_q <= pwdata;
        brb_pkg::REG_START_MARKER_LEN: start_len_q    <= pwdata[brb_pkg::MLEN_W-1:0];
        brb_pkg::REG_END_MARKER:       end_marker_q   <= pwdata;
        brb_pkg::REG_END_MARKER_LEN:   end_len_q      <= pwdata[brb_pkg::MLEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign slen = brb_pkg::clamp_len(start_len_q);
  assign elen = brb_pkg::clamp_len(end_len_q);

  // ---------------------------------------------------------------------------
  // handshake: take a beat only when idle and the result register is free
  // or being drained this cycle
  // ---------------------------------------------------------------------------
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // end marker offset of the byte now compared
  assign e_off = idx_q - CW'(elen) + CW'(1);

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    fill_d      = fill_q;
    rd_idx_d    = rd_idx_q;
    idx_d       = idx_q;
    dv_d        = 1'b0;
    end_phase_d = end_phase_q;
    s_d         = s_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;

    ram_we      = 1'b0;
    ram_waddr   = wp_q;
    ram_re      = 1'b0;
    ram_raddr   = rp_q;

    mctl        = '{shift: 1'b0, clear: 1'b0, use_end: end_phase_q};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          out_d.status       = brb_pkg::STAT_DONE;
          out_d.read_byte    = '0;
          out_d.frame_length = '0;
          out_d.fill_level   = brb_pkg::FIELD_LEN_W'(fill_q);
          unique case (in_data_i.cmd)
            brb_pkg::CMD_PUT: begin
              out_valid_d = 1'b1;
              if (fill_q == FULL_CNT) begin
                out_d.status = brb_pkg::STAT_FULL;
              end else begin
                ram_we           = 1'b1;
                wp_d             = wp_q + AW'(1);
                fill_d           = fill_q + CW'(1);
                out_d.fill_level = brb_pkg::FIELD_LEN_W'(fill_d);
              end
            end
            brb_pkg::CMD_GET: begin
              if (fill_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = brb_pkg::STAT_EMPTY;
              end else begin
                ram_re  = 1'b1;
                state_d = ST_GET;
              end
            end
            brb_pkg::CMD_FIND: begin
              if (fill_q == '0) begin
                out_valid_d  = 1'b1;
                out_d.status = brb_pkg::STAT_NOT_FOUND;
              end else begin
                // fresh scan from the oldest byte, start marker first
                rd_idx_d    = '0;
                end_phase_d = 1'b0;
                mctl.clear  = 1'b1;
                state_d     = ST_FIND;
              end
            end
            default: begin
              // unused command: plain status beat, nothing changes
              out_valid_d = 1'b1;
            end
          endcase
        end
      end

      ST_GET: begin
        out_valid_d        = 1'b1;
        out_d.status       = brb_pkg::STAT_DONE;
        out_d.read_byte    = ram_rdata;
        out_d.frame_length = '0;
        fill_d             = fill_q - CW'(1);
        rp_d               = rp_q + AW'(1);
        if (fill_d == '0) begin
          // ring drained, both pointers back to the start
          rp_d = '0;
          wp_d = '0;
        end
        out_d.fill_level = brb_pkg::FIELD_LEN_W'(fill_d);
        state_d          = ST_IDLE;
      end

      ST_FIND: begin
        // issue one read per cycle while held bytes remain
        if (rd_idx_q < fill_q) begin
          ram_re    = 1'b1;
          ram_raddr = rp_q + rd_idx_q[AW-1:0];
          rd_idx_d  = rd_idx_q + CW'(1);
          idx_d     = rd_idx_q;
          dv_d      = 1'b1;
        end
        mctl.shift = dv_q;
        if (dv_q && hit && !end_phase_q) begin
          // start marker found, end search begins right after it
          s_d         = idx_q - CW'(slen) + CW'(1);
          end_phase_d = 1'b1;
          mctl.clear  = 1'b1;
        end else if (dv_q && hit && end_phase_q) begin
          // frame found: drop the bytes ahead of the start marker
          ram_re             = 1'b0;
          dv_d               = 1'b0;
          rp_d               = rp_q + s_q[AW-1:0];
          fill_d             = fill_q - s_q;
          out_valid_d        = 1'b1;
          out_d.status       = brb_pkg::STAT_DONE;
          out_d.read_byte    = '0;
          out_d.frame_length = brb_pkg::FIELD_LEN_W'(e_off - s_q);
          out_d.fill_level   = brb_pkg::FIELD_LEN_W'(fill_d);
          state_d            = ST_IDLE;
        end else if (!dv_q && (rd_idx_q == fill_q)) begin
          // every held byte compared without a whole frame
          out_valid_d        = 1'b1;
          out_d.status       = brb_pkg::STAT_NOT_FOUND;
          out_d.read_byte    = '0;
          out_d.frame_length = '0;
          out_d.fill_level   = brb_pkg::FIELD_LEN_W'(fill_q);
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wp_q        <= '0;
      rp_q        <= '0;
      fill_q      <= '0;
      rd_idx_q    <= '0;
      dv_q        <= 1'b0;
      end_phase_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wp_q        <= wp_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      rd_idx_q    <= rd_idx_d;
      dv_q        <= dv_d;
      end_phase_q <= end_phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    s_q   <= s_d;
    out_q <= out_d;
  end

  // ---------------------------------------------------------------------------
  // byte store and marker compare unit
  // ---------------------------------------------------------------------------
  brb_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_data_i.data_byte),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  brb_match u_match (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (mctl),
    .byte_i         (ram_rdata),
    .start_marker_i (start_marker_q),
    .start_len_i    (start_len_q),
    .end_marker_i   (end_marker_q),
    .end_len_i      (end_len_q),
    .hit_o          (hit)
  );

endmodule

// File: tb/tb_byte_ring_buffer_frame_find.sv
`timescale 1ns / 1ps

module tb_byte_ring_buffer_frame_find;
  import brb_pkg::*;

  localparam int RING_DEPTH = DEPTH_DEFAULT;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int ITEM_GOAL  = 1950;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every block input starts at a known value
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [PADDR_W-1:0]  paddr   = '0;
  logic [PDATA_W-1:0]  pwdata  = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // request beats still to be offered, and the answers owed by the block
  in_t  req_q[$];
  out_t answers_q[$];

  int errors       = 0;
  int items_queued = 0;
  int answers_seen = 0;

  // steady: no idling on either side; hold_req: ask the receiver for one long hold-off
  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  // ring model: storage, pointers and fill count
  logic [7:0]       ring_mem [RING_DEPTH];
  logic [PTR_W-1:0] ring_wr = '0;
  logic [PTR_W-1:0] ring_rd = '0;
  int               ring_fill = 0;

  // marker register copies, reset values
  logic [31:0] cfg_start     = '0;
  logic [2:0]  cfg_start_len = 3'd1;
  logic [31:0] cfg_end       = '0;
  logic [2:0]  cfg_end_len   = 3'd1;

  byte_ring_buffer_frame_find dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // a marker length of 0 behaves as 1, anything above 4 as 4
  function automatic int eff_len(input logic [2:0] n);
    int r;
    r = n;
    if (n == 3'd0) begin
      r = 1;
    end else if (n > 3'd4) begin
      r = 4;
    end
    return r;
  endfunction

  // first offset from the oldest byte, at or after from, where the whole marker is held
  function automatic int seek_marker(input int from, input logic [31:0] mk, input int len);
    int  off;
    int  i;
    bit  hit;
    for (off = from; off + len <= ring_fill; off++) begin
      hit = 1'b1;
      for (i = 0; i < len; i++) begin
        if (ring_mem[(ring_rd + off + i) & (RING_DEPTH - 1)] != mk[8*i +: 8]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        return off;
      end
    end
    return ring_fill;
  endfunction

  // apply one request to the ring model and return the answer it owes
  function automatic out_t ring_apply(input in_t req);
    out_t res;
    int   s;
    int   e;
    int   slen;
    int   elen;
    res        = '0;
    res.status = STAT_DONE;
    case (req.cmd)
      CMD_PUT: begin
        if (ring_fill >= RING_DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          ring_mem[ring_wr] = req.data_byte;
          ring_wr           = ring_wr + 1'b1;
          ring_fill++;
        end
      end
      CMD_GET: begin
        if (ring_fill == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          res.read_byte = ring_mem[ring_rd];
          ring_rd       = ring_rd + 1'b1;
          ring_fill--;
          // an emptied ring starts again from slot zero
          if (ring_fill == 0) begin
            ring_rd = '0;
            ring_wr = '0;
          end
        end
      end
      CMD_FIND: begin
        slen = eff_len(cfg_start_len);
        elen = eff_len(cfg_end_len);
        s    = seek_marker(0, cfg_start, slen);
        e    = ring_fill;
        // the end marker may only begin past the whole start marker
        if (s != ring_fill) begin
          e = seek_marker(s + slen, cfg_end, elen);
        end
        if (e != ring_fill) begin
          ring_rd          = ring_rd + PTR_W'(s);
          ring_fill        = ring_fill - s;
          res.frame_length = FIELD_LEN_W'(e - s);
        end else begin
          res.status = STAT_NOT_FOUND;
        end
      end
      default: begin
        // unused command leaves everything alone
      end
    endcase
    res.fill_level = FIELD_LEN_W'(ring_fill);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  // request driver: accepted beats go through the ring model, then the next one is offered
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready) begin
        answers_q.push_back(ring_apply(in_data));
      end
      // a new beat may only be offered once the current one has gone
      if (!in_valid || in_ready) begin
        if (req_q.size() > 0 && (steady || $urandom_range(99) >= 15)) begin
          in_valid <= 1'b1;
          in_data  <= req_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver ready, with one long hold-off counted here so that the block backs up
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 400;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady || $urandom_range(99) >= 15;
    end
  end

  // result monitor: each beat against the oldest answer owed
  always @(posedge clk_i) begin : result_check
    out_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (answers_q.size() == 0) begin
        report_mismatch($sformatf("result beat %0d with no request outstanding", answers_seen));
      end else begin
        want = answers_q.pop_front();
        if (out_data.status !== want.status) begin
          report_mismatch($sformatf("beat %0d status got %0d expected %0d",
                                    answers_seen, out_data.status, want.status));
        end
        if (out_data.read_byte !== want.read_byte) begin
          report_mismatch($sformatf("beat %0d read_byte got %0h expected %0h",
                                    answers_seen, out_data.read_byte, want.read_byte));
        end
        if (out_data.frame_length !== want.frame_length) begin
          report_mismatch($sformatf("beat %0d frame_length got %0d expected %0d",
                                    answers_seen, out_data.frame_length, want.frame_length));
        end
        if (out_data.fill_level !== want.fill_level) begin
          report_mismatch($sformatf("beat %0d fill_level got %0d expected %0d",
                                    answers_seen, out_data.fill_level, want.fill_level));
        end
      end
      answers_seen++;
    end
  end

  // register write: setup cycle, then access cycle; the write lands on the access edge
  task automatic cfg_write(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_MARKER:     cfg_start     = val;
      REG_START_MARKER_LEN: cfg_start_len = val[2:0];
      REG_END_MARKER:       cfg_end       = val;
      REG_END_MARKER_LEN:   cfg_end_len   = val[2:0];
      default: ;
    endcase
  endtask

  task automatic cfg_setup(input logic [31:0] sm, input logic [31:0] sl,
                           input logic [31:0] em, input logic [31:0] el);
    cfg_write(REG_START_MARKER, sm);
    cfg_write(REG_START_MARKER_LEN, sl);
    cfg_write(REG_END_MARKER, em);
    cfg_write(REG_END_MARKER_LEN, el);
  endtask

  task automatic push_req(input cmd_e c, input logic [7:0] b);
    req_q.push_back(in_t'{cmd: c, data_byte: b});
    items_queued++;
  endtask

  // sender pause: every beat taken and every answer back, then a short settle
  task automatic wait_drained();
    do begin
      @(negedge clk_i);
    end while (req_q.size() != 0 || in_valid || answers_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  // noise, start marker, body, end marker, find, then some gets
  // a broken frame spoils or leaves out one marker, or looks for the frame too early
  task automatic push_frame(input bit broken);
    int         slen;
    int         elen;
    int         n_noise;
    int         n_body;
    int         spoil;
    int         i;
    logic [7:0] b;
    slen    = eff_len(cfg_start_len);
    elen    = eff_len(cfg_end_len);
    n_noise = $urandom_range(0, 4);
    n_body  = $urandom_range(0, 12);
    spoil   = broken ? $urandom_range(0, 3) : -1;
    for (i = 0; i < n_noise; i++) begin
      push_req(CMD_PUT, 8'($urandom));
    end
    for (i = 0; i < slen; i++) begin
      b = cfg_start[8*i +: 8];
      if (spoil == 0 && i == slen - 1) begin
        b = ~b;
      end
      push_req(CMD_PUT, b);
    end
    for (i = 0; i < n_body; i++) begin
      push_req(CMD_PUT, 8'($urandom));
    end
    if (spoil == 3) begin
      push_req(CMD_FIND, 8'($urandom));
    end
    if (spoil != 1) begin
      for (i = 0; i < elen; i++) begin
        b = cfg_end[8*i +: 8];
        if (spoil == 2 && i == 0) begin
          b = ~b;
        end
        push_req(CMD_PUT, b);
      end
    end
    if (spoil != 3) begin
      push_req(CMD_FIND, 8'($urandom));
    end
    repeat ($urandom_range(0, n_noise + slen + n_body + elen + 2)) begin
      push_req(CMD_GET, 8'($urandom));
    end
  endtask

  // safety net against a hung block
  initial begin
    #100_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    int         ph;
    int         i;
    int         r;
    int         n_noise;
    int         slen;
    int         elen;
    logic [7:0] b;
    logic [31:0] mk;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty ring, unused command, a simple frame, no start, end before start
    cfg_setup(32'h0000_007E, 32'd1, 32'h0000_007F, 32'd1);
    @(negedge clk_i);
    push_req(CMD_GET,  8'hFF);
    push_req(CMD_FIND, 8'h00);
    push_req(CMD_NONE, 8'hFF);
    push_req(CMD_PUT,  8'h00);
    push_req(CMD_PUT,  8'hFF);
    push_req(CMD_GET,  8'h00);
    push_req(CMD_NONE, 8'h00);
    push_req(CMD_PUT,  8'h11);
    push_req(CMD_PUT,  8'h7E);
    push_req(CMD_PUT,  8'h41);
    push_req(CMD_PUT,  8'h7E);
    push_req(CMD_PUT,  8'h7F);
    push_req(CMD_PUT,  8'h22);
    push_req(CMD_FIND, 8'hAA);
    push_req(CMD_FIND, 8'h55);
    push_req(CMD_GET,  8'h00);
    push_req(CMD_GET,  8'h00);
    push_req(CMD_GET,  8'h00);
    push_req(CMD_FIND, 8'h00);
    push_req(CMD_PUT,  8'h7E);
    push_req(CMD_FIND, 8'h00);
    repeat (4) push_req(CMD_GET, 8'hFF);
    wait_drained();

    // full ring without any idling: whole-ring walk with no start, rejected puts,
    // then a find near the top that throws away almost everything and leaves the
    // pointers close to the wrap
    steady = 1'b1;
    cfg_setup($urandom, 32'd3, $urandom, 32'd2);
    @(negedge clk_i);
    slen    = eff_len(cfg_start_len);
    elen    = eff_len(cfg_end_len);
    n_noise = RING_DEPTH - slen - 2 - elen;
    repeat (ring_fill + 2) push_req(CMD_GET, 8'($urandom));
    for (i = 0; i < n_noise; i++) begin
      b = 8'($urandom);
      // keep the start marker out of the noise
      if (b == cfg_start[7:0]) begin
        b = b ^ 8'h01;
      end
      push_req(CMD_PUT, b);
    end
    push_req(CMD_FIND, 8'($urandom));
    for (i = 0; i < slen; i++) begin
      push_req(CMD_PUT, cfg_start[8*i +: 8]);
    end
    push_req(CMD_PUT, 8'($urandom));
    push_req(CMD_PUT, 8'($urandom));
    for (i = 0; i < elen; i++) begin
      push_req(CMD_PUT, cfg_end[8*i +: 8]);
    end
    repeat (3) push_req(CMD_PUT, 8'($urandom));
    push_req(CMD_NONE, 8'($urandom));
    push_req(CMD_FIND, 8'($urandom));
    repeat (12) push_req(CMD_PUT, 8'($urandom));
    repeat (24) push_req(CMD_GET, 8'($urandom));
    wait_drained();
    steady = 1'b0;

    // random phases, each with its own marker setting
    for (ph = 0; items_queued < ITEM_GOAL; ph++) begin
      mk = $urandom;
      case (ph % 6)
        0: cfg_setup($urandom, 32'd4, $urandom, 32'd4);
        1: cfg_setup(32'h0000_0000, 32'd0, 32'hFFFF_FFFF, 32'd7);
        2: cfg_setup(32'hFFFF_FFFF, 32'd5, 32'h0000_0000, 32'd0);
        // start and end share one marker
        3: cfg_setup(mk, 32'd2, mk, 32'd2);
        4: cfg_setup($urandom, $urandom_range(0, 7), $urandom, $urandom_range(0, 7));
        default: cfg_setup(mk, 32'd1, mk, 32'd3);
      endcase
      @(negedge clk_i);
      while (req_q.size() < 150) begin
        r = $urandom_range(99);
        if (r < 70) begin
          push_frame(1'b0);
        end else if (r < 85) begin
          push_frame(1'b1);
        end else if (r < 95) begin
          repeat (5) push_req(cmd_e'($urandom_range(0, 3)), 8'($urandom));
        end else begin
          repeat (8) push_req(CMD_GET, 8'($urandom));
        end
      end
      // second phase: the receiver stops for a long while and the ring backs up
      if (ph == 1) begin
        hold_req = 1'b1;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/brb_pkg.sv
rtl/core/brb_ram.sv
rtl/core/brb_match.sv
rtl/core/byte_ring_buffer_frame_find.sv
tb/tb_byte_ring_buffer_frame_find.sv
